// ===== rtl/core/sust_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted unique set table package
// Shared types, operation codes and constants for the sorted set table.
// ----------------------------------------------------------------------------
package sust_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Flipping the sign bit makes an unsigned compare give the signed order.
   localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] rank;
      logic       dropped;
      logic [6:0] occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_APPLY
   } state_type;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

// ===== rtl/core/sust_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one table entry, compares it against the broadcast key and shifts
// toward or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sust_cell
   import sust_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [31:0]        key,
   input  logic [CNT_W-1:0]   count,
   input  logic [31:0]        left_entry,
   input  logic               left_lt,
   input  logic [31:0]        right_entry,
   output logic [31:0]        entry,
   output logic               lt,
   output logic               eq
);

   logic [31:0] entry_ff;
   logic        lt_ff;
   logic        eq_ff;
   logic        occupied;

   assign occupied = CNT_W'(INDEX) < count;

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         lt_ff <= occupied && (entry_ff < key);
         eq_ff <= occupied && (entry_ff == key);
      end
   end

   // Cells below the insertion point keep their entry. The first cell at or
   // above it takes the key, and the rest take their left neighbor's entry.
   always_ff @(posedge clock) begin
      if (cmd.insert && !lt_ff) begin
         entry_ff <= left_lt ? key : left_entry;
      end else if (cmd.remove && !lt_ff) begin
         entry_ff <= right_entry;
      end
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== rtl/core/sust_reduce.sv =====
// ----------------------------------------------------------------------------
// Sorted set match reducer
// Collapses the per-cell match flags into a hit flag and the matching rank.
// ----------------------------------------------------------------------------
module sust_reduce
   import sust_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int IDX_W    = 6
) (
   input  logic [CAPACITY-1:0] eq,
   output logic                hit,
   output logic [IDX_W-1:0]    rank
);

   // At most one cell matches, since the table holds no duplicates.
   always_comb begin
      rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq[i]) begin
            rank = rank | IDX_W'(i);
         end
      end
   end

   assign hit = |eq;

endmodule

// ===== rtl/core/sorted_unique_set_table.sv =====
// ----------------------------------------------------------------------------
// Sorted unique set table
// Ordered set of signed 32-bit keys held in a chain of compare-and-shift
// cells, with insert, remove and search operations.
// ----------------------------------------------------------------------------
// Each item passes through the accept edge, a compare state in which every
// cell compares its entry to the key, a reduce state reducing the match flags
// to a hit and rank, and an apply state in which the cells shift and the
// result is registered. busy is high during that time, so a new item can be
// started in the cycle the result appears. The result is shown for exactly
// one cycle with rsp_valid high; the receiver cannot stall it and must take
// it then.
// ----------------------------------------------------------------------------
module sorted_unique_set_table
   import sust_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type        state_ff, state_in;
   cell_cmd_type     cmd;
   logic [1:0]       op_ff;
   logic [31:0]      key_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] rank_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [31:0]        entry_w [CAPACITY];
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] eq_w;
   logic               red_hit;
   logic [IDX_W-1:0]   red_rank;
   logic               accept;
   logic               full;
   logic               do_insert;
   logic               do_remove;
   logic               dropped;

   assign accept = start && !busy;

   // ---------------------------------------------------------------- cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] left_entry;
      logic        left_lt;
      logic [31:0] right_entry;

      // The first cell has nothing below it, so it takes the key whenever
      // the insertion point is at the head of the table.
      if (g == 0) begin : g_first
         assign left_entry = key_ff;
         assign left_lt    = 1'b1;
      end else begin : g_inner
         assign left_entry = entry_w[g-1];
         assign left_lt    = lt_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = key_ff;
      end else begin : g_body
         assign right_entry = entry_w[g+1];
      end

      sust_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .key         (key_ff),
         .count       (count_ff),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (entry_w[g]),
         .lt          (lt_w[g]),
         .eq          (eq_w[g])
      );
   end

   sust_reduce #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_reduce (
      .eq   (eq_w),
      .hit  (red_hit),
      .rank (red_rank)
   );

   // ------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.insert = do_insert;
            cmd.remove = do_remove;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.op;
         key_ff <= req_data.value ^ SIGN_BIAS;
      end
      if (state_ff == ST_REDUCE) begin
         hit_ff  <= red_hit;
         rank_ff <= red_rank;
      end
   end

   // -------------------------------------------------------- apply/result
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign do_insert = (op_ff == OP_INSERT) && !hit_ff && !full;
   assign do_remove = (op_ff == OP_REMOVE) && hit_ff;
   assign dropped   = (op_ff == OP_INSERT) && !hit_ff && full;

   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_APPLY) begin
         if (do_insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_remove) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in.hit       = hit_ff;
      rsp_in.rank      = hit_ff ? 6'(rank_ff) : 6'd0;
      rsp_in.dropped   = dropped;
      rsp_in.occupancy = 7'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= state_ff == ST_APPLY;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_APPLY) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
